// ===== sv/pidmc_pkg.sv =====
`default_nettype none

package pidmc_pkg;

  localparam int SampleW = 16;
  localparam int GainW   = 16;
  localparam int LimitW  = 15;
  localparam int OutLimW = 8;
  localparam int SumW    = 32;
  localparam int TermW   = SampleW;
  localparam int ProdW   = GainW + 1 + TermW;
  localparam int TotalW  = ProdW + 2;
  localparam int MagW    = 16;
  localparam int DirW    = 2;
  localparam int IndexW  = 3;
  localparam int DataW   = 16;

  typedef enum logic [IndexW-1:0] {
    REG_GAIN_P      = 3'd0,
    REG_GAIN_I      = 3'd1,
    REG_GAIN_OFFSET = 3'd2,
    REG_TARGET      = 3'd3,
    REG_INT_LIMIT   = 3'd4,
    REG_RATE_LIMIT  = 3'd5,
    REG_OUT_LIMIT   = 3'd6
  } pidmc_reg_t;

  localparam logic [DirW-1:0] DIR_ZERO = 2'b00;
  localparam logic [DirW-1:0] DIR_POS  = 2'b01;
  localparam logic [DirW-1:0] DIR_NEG  = 2'b11;

  typedef struct packed {
    logic [GainW-1:0]          gain_proportional;
    logic [GainW-1:0]          gain_integral;
    logic [GainW-1:0]          gain_offset;
    logic signed [SampleW-1:0] target_value;
    logic [LimitW-1:0]         integral_limit;
    logic [LimitW-1:0]         rate_limit;
    logic [OutLimW-1:0]        output_limit;
  } pidmc_cfg_t;

  localparam pidmc_cfg_t CFG_RESET = '{
    gain_proportional: 16'd0,
    gain_integral:     16'd0,
    gain_offset:       16'd0,
    target_value:      16'sd10,
    integral_limit:    15'd850,
    rate_limit:        15'd850,
    output_limit:      8'd90
  };

  typedef struct packed {
    logic signed [ProdW-1:0] p_term;
    logic signed [ProdW-1:0] i_term;
    logic signed [ProdW-1:0] d_term;
  } pidmc_terms_t;

endpackage

`default_nettype wire

// ===== sv/pidmc_if.sv =====
`default_nettype none

interface pidmc_in_if;
  logic                 valid;
  logic                 ready;
  logic signed [15:0]   error_sample;
  modport source (output valid, output error_sample, input ready);
  modport sink (input valid, input error_sample, output ready);
endinterface

interface pidmc_out_if;
  logic                 valid;
  logic                 ready;
  logic signed [1:0]    direction;
  logic [15:0]          correction_magnitude;
  modport source (output valid, output direction, output correction_magnitude, input ready);
  modport sink (input valid, input direction, input correction_magnitude, output ready);
endinterface

interface pidmc_cfg_if;
  logic                 valid;
  logic                 ready;
  logic [2:0]           index;
  logic [15:0]          data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/pidmc_terms.sv =====
`default_nettype none

module pidmc_terms
  import pidmc_pkg::*;
(
  input  pidmc_cfg_t                cfg_q,
  input  logic signed [SampleW-1:0] sample,
  input  logic signed [SumW-1:0]    sum,
  output pidmc_terms_t              terms
);

  logic signed [SumW-1:0]    int_lim;
  logic signed [SumW-1:0]    int_lim_neg;
  logic signed [TermW-1:0]   i_in;
  logic signed [SampleW:0]   diff;
  logic signed [SampleW:0]   rate_lim;
  logic signed [SampleW:0]   rate_lim_neg;
  logic signed [TermW-1:0]   d_in;
  logic signed [GainW:0]     kp;
  logic signed [GainW:0]     ki;
  logic signed [GainW:0]     kd;

  // symmetric clamp of the running sum
  always_comb begin
    int_lim     = $signed({{(SumW-LimitW){1'b0}}, cfg_q.integral_limit});
    int_lim_neg = -int_lim;
    if (sum > int_lim) begin
      i_in = int_lim[TermW-1:0];
    end else if (sum < int_lim_neg) begin
      i_in = int_lim_neg[TermW-1:0];
    end else begin
      i_in = sum[TermW-1:0];
    end
  end

  // symmetric clamp of sample minus setpoint
  always_comb begin
    diff         = {sample[SampleW-1], sample} -
                   {cfg_q.target_value[SampleW-1], cfg_q.target_value};
    rate_lim     = $signed({{(SampleW+1-LimitW){1'b0}}, cfg_q.rate_limit});
    rate_lim_neg = -rate_lim;
    if (diff > rate_lim) begin
      d_in = rate_lim[TermW-1:0];
    end else if (diff < rate_lim_neg) begin
      d_in = rate_lim_neg[TermW-1:0];
    end else begin
      d_in = diff[TermW-1:0];
    end
  end

  assign kp = $signed({1'b0, cfg_q.gain_proportional});
  assign ki = $signed({1'b0, cfg_q.gain_integral});
  assign kd = $signed({1'b0, cfg_q.gain_offset});

  assign terms.p_term = ProdW'(kp) * ProdW'(sample);
  assign terms.i_term = ProdW'(ki) * ProdW'(i_in);
  assign terms.d_term = ProdW'(kd) * ProdW'(d_in);

endmodule

`default_nettype wire

// ===== sv/pid_motor_correction.sv =====
// an accepted item passes the s1, s2, s3 and output registers before its result is offered
// throughput: one item per cycle while corrections.ready does not stall it, set by the four-stage pipeline
// (sum update, clamp and multiply, three-term add, sign and output clamp)
// rst (synchronous) clears the running sum and pipeline valids and
// loads the register defaults
`default_nettype none

module pid_motor_correction
  import pidmc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  pidmc_in_if.sink    samples,
  pidmc_out_if.source corrections,
  pidmc_cfg_if.sink   cfg
);

  pidmc_cfg_t                cfg_q;
  logic signed [SumW-1:0]    error_sum;
  logic signed [SumW:0]      acc;
  logic signed [SumW-1:0]    sum_next;

  logic                      s1_valid;
  logic signed [SampleW-1:0] s1_sample;
  logic signed [SumW-1:0]    s1_sum;
  logic                      s2_valid;
  pidmc_terms_t              s2_terms;
  pidmc_terms_t              terms;
  logic                      s3_valid;
  logic signed [TotalW-1:0]  s3_total;
  logic signed [TotalW-1:0]  total_next;

  logic                      out_valid;
  logic [DirW-1:0]           out_direction;
  logic [MagW-1:0]           out_magnitude;
  logic [DirW-1:0]           dir_next;
  logic [TotalW-1:0]         abs_total;
  logic [MagW-1:0]           cap;
  logic [MagW-1:0]           mag_next;

  logic                      out_en;
  logic                      s3_en;
  logic                      s2_en;
  logic                      s1_en;
  logic                      in_accept;

  assign out_en    = !out_valid || corrections.ready;
  assign s3_en     = !s3_valid || out_en;
  assign s2_en     = !s2_valid || s3_en;
  assign s1_en     = !s1_valid || s2_en;
  assign in_accept = samples.valid && s1_en && !rst;

  assign samples.ready = s1_en && !rst;
  assign cfg.ready     = !rst;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q <= CFG_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_GAIN_P:      cfg_q.gain_proportional <= cfg.data[GainW-1:0];
        REG_GAIN_I:      cfg_q.gain_integral <= cfg.data[GainW-1:0];
        REG_GAIN_OFFSET: cfg_q.gain_offset <= cfg.data[GainW-1:0];
        REG_TARGET:      cfg_q.target_value <= $signed(cfg.data[SampleW-1:0]);
        REG_INT_LIMIT:   cfg_q.integral_limit <= cfg.data[LimitW-1:0];
        REG_RATE_LIMIT:  cfg_q.rate_limit <= cfg.data[LimitW-1:0];
        REG_OUT_LIMIT:   cfg_q.output_limit <= cfg.data[OutLimW-1:0];
        default: ;
      endcase
    end
  end

  // saturating running sum
  always_comb begin
    acc = {error_sum[SumW-1], error_sum} +
          {{(SumW+1-SampleW){samples.error_sample[SampleW-1]}}, samples.error_sample};
    if (acc[SumW] != acc[SumW-1]) begin
      sum_next = acc[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
    end else begin
      sum_next = acc[SumW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum <= '0;
    end else if (in_accept) begin
      error_sum <= sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_en) begin
      s1_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_sample <= samples.error_sample;
      s1_sum    <= sum_next;
    end
  end

  pidmc_terms u_terms (
    .cfg_q  (cfg_q),
    .sample (s1_sample),
    .sum    (s1_sum),
    .terms  (terms)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en && s1_valid) begin
      s2_terms <= terms;
    end
  end

  assign total_next = {{2{s2_terms.p_term[ProdW-1]}}, s2_terms.p_term} +
                      {{2{s2_terms.i_term[ProdW-1]}}, s2_terms.i_term} +
                      {{2{s2_terms.d_term[ProdW-1]}}, s2_terms.d_term};

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_en && s2_valid) begin
      s3_total <= total_next;
    end
  end

  // sign, magnitude and output clamp
  always_comb begin
    cap = {cfg_q.output_limit, 8'h00};
    if (s3_total[TotalW-1]) begin
      dir_next  = DIR_NEG;
      abs_total = -s3_total;
    end else if (s3_total != '0) begin
      dir_next  = DIR_POS;
      abs_total = s3_total;
    end else begin
      dir_next  = DIR_ZERO;
      abs_total = '0;
    end
    if (abs_total > {{(TotalW-MagW){1'b0}}, cap}) begin
      mag_next = cap;
    end else begin
      mag_next = abs_total[MagW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_en) begin
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && s3_valid) begin
      out_direction <= dir_next;
      out_magnitude <= mag_next;
    end
  end

  assign corrections.valid                = out_valid;
  assign corrections.direction            = $signed(out_direction);
  assign corrections.correction_magnitude = out_magnitude;

`ifndef SYNTH
  a_sum_holds: assert property (@(posedge clk) disable iff (rst)
    !in_accept |=> $stable(error_sum))
    else $error("running sum changed without an item");

  a_zero_dir_zero_mag: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_direction == DIR_ZERO) |-> out_magnitude == '0)
    else $error("zero direction with nonzero magnitude");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !samples.ready |-> (s1_valid && s2_valid && s3_valid && out_valid))
    else $error("input stalled with a free pipeline stage");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/pid_motor_correction_tb.sv =====
`timescale 1ns / 100ps

module pid_motor_correction_tb
  import pidmc_pkg::*;
;

  localparam logic [IndexW-1:0] REG_NONE = 3'd7;
  localparam longint SumMax = 64'sh0000_0000_7FFF_FFFF;
  localparam longint SumMin = -64'sh0000_0000_8000_0000;
  localparam int RandomPhases = 8;
  localparam int PhaseItems = 230;
  localparam int ExtremeItems = 60;

  typedef struct packed {
    logic [DirW-1:0] dir;
    logic [MagW-1:0] mag;
  } correction_t;

  typedef struct packed {
    logic [IndexW-1:0] idx;
    logic [DataW-1:0]  data;
  } reg_write_t;

  class correction_scoreboard;
    logic [GainW-1:0]          kp;
    logic [GainW-1:0]          ki;
    logic [GainW-1:0]          kd;
    logic signed [SampleW-1:0] setpoint;
    logic [LimitW-1:0]         sum_clamp;
    logic [LimitW-1:0]         rate_clamp;
    logic [OutLimW-1:0]        out_cap;
    logic signed [SumW-1:0]    err_acc;
    correction_t               awaited[$];
    int                        checked;
    int                        mismatches;
    bit                        hit_max;
    bit                        hit_min;

    function new();
      kp = '0;
      ki = '0;
      kd = '0;
      setpoint = 16'sd10;
      sum_clamp = 15'd850;
      rate_clamp = 15'd850;
      out_cap = 8'd90;
      err_acc = '0;
      checked = 0;
      mismatches = 0;
      hit_max = 1'b0;
      hit_min = 1'b0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void set_reg(logic [IndexW-1:0] idx, logic [DataW-1:0] value);
      case (idx)
        REG_GAIN_P:      kp = value;
        REG_GAIN_I:      ki = value;
        REG_GAIN_OFFSET: kd = value;
        REG_TARGET:      setpoint = value;
        REG_INT_LIMIT:   sum_clamp = value[LimitW-1:0];
        REG_RATE_LIMIT:  rate_clamp = value[LimitW-1:0];
        REG_OUT_LIMIT:   out_cap = value[OutLimW-1:0];
        default: ;
      endcase
    endfunction

    function longint clamp_sym(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    function void note_sample(logic signed [SampleW-1:0] s);
      longint      acc;
      longint      total;
      longint      mag;
      longint      cap;
      correction_t c;
      acc = longint'(err_acc) + longint'(s);
      if (acc >= SumMax) begin
        acc = SumMax;
        hit_max = 1'b1;
      end else if (acc <= SumMin) begin
        acc = SumMin;
        hit_min = 1'b1;
      end
      err_acc = acc[SumW-1:0];
      total = longint'(kp) * longint'(s)
            + longint'(ki) * clamp_sym(longint'(err_acc), longint'(sum_clamp))
            + longint'(kd) * clamp_sym(longint'(s) - longint'(setpoint),
                                       longint'(rate_clamp));
      if (total > 0) begin
        c.dir = DIR_POS;
        mag = total;
      end else if (total < 0) begin
        c.dir = DIR_NEG;
        mag = -total;
      end else begin
        c.dir = DIR_ZERO;
        mag = 0;
      end
      cap = longint'(out_cap) << 8;
      if (mag > cap) mag = cap;
      c.mag = mag[MagW-1:0];
      awaited.push_back(c);
    endfunction

    function void check_result(logic [DirW-1:0] dir, logic [MagW-1:0] mag);
      correction_t c;
      if (awaited.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected correction, direction %0d magnitude %0d",
                 $time, $signed(dir), mag);
        return;
      end
      c = awaited.pop_front();
      checked++;
      if (dir !== c.dir) begin
        mismatches++;
        $display("%0t: direction expected %0d actual %0d",
                 $time, $signed(c.dir), $signed(dir));
      end
      if (mag !== c.mag) begin
        mismatches++;
        $display("%0t: correction_magnitude expected %0d actual %0d",
                 $time, c.mag, mag);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   sender_steady;
  bit   sink_steady;
  int   samples_sent;
  int   writes_done;

  correction_scoreboard sb = new();

  pidmc_in_if  samples();
  pidmc_out_if corrections();
  pidmc_cfg_if cfg();

  pid_motor_correction i_dut (
    .clk         (clk),
    .rst         (rst),
    .samples     (samples),
    .corrections (corrections),
    .cfg         (cfg)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #15_000_000;
    $display("pid_motor_correction regression: fail");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && corrections.valid && corrections.ready) begin
      sb.check_result(corrections.direction, corrections.correction_magnitude);
    end
  end

  initial begin
    int stall;
    corrections.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = sink_steady ? 0 : $urandom_range(0, 12);
      if (stall != 0) begin
        corrections.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      corrections.ready <= 1'b1;
      do @(posedge clk); while (!corrections.valid);
    end
  end

  function automatic reg_write_t wr(logic [IndexW-1:0] idx, logic [DataW-1:0] data);
    reg_write_t w;
    w.idx = idx;
    w.data = data;
    return w;
  endfunction

  // style 0 low extreme, 1 high extreme, otherwise random
  function automatic logic [DataW-1:0] reg_value(logic [IndexW-1:0] idx, int style);
    bit is_gain;
    is_gain = (idx == REG_GAIN_P) || (idx == REG_GAIN_I) || (idx == REG_GAIN_OFFSET);
    case (style)
      0: return (idx == REG_TARGET) ? 16'h8000 : 16'h0000;
      1: return (idx == REG_TARGET) ? 16'h7FFF : 16'hFFFF;
      default: begin
        if (is_gain && $urandom_range(0, 2) != 0) return DataW'($urandom_range(0, 400));
        return DataW'($urandom());
      end
    endcase
  endfunction

  function automatic logic signed [SampleW-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0, 1: return SampleW'($urandom_range(0, 128) - 64);
      2:    return SampleW'(sb.setpoint + ($urandom_range(0, 32) - 16));
      3:    return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      default: return SampleW'($urandom());
    endcase
  endfunction

  task automatic send_sample(input logic signed [SampleW-1:0] value);
    int gap;
    gap = sender_steady ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      samples.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    samples.valid <= 1'b1;
    samples.error_sample <= value;
    do @(posedge clk); while (!samples.ready);
    sb.note_sample(value);
    samples_sent++;
  endtask

  task automatic drain_corrections();
    samples.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic program_regs(input reg_write_t plan[$]);
    foreach (plan[k]) begin
      cfg.valid <= 1'b1;
      cfg.index <= plan[k].idx;
      cfg.data <= plan[k].data;
      do @(posedge clk); while (!cfg.ready);
      sb.set_reg(plan[k].idx, plan[k].data);
      writes_done++;
    end
    cfg.valid <= 1'b0;
  endtask

  initial begin
    reg_write_t               plan[$];
    logic signed [SampleW-1:0] probe[$];
    int                        style;
    rst <= 1'b1;
    samples.valid <= 1'b0;
    samples.error_sample <= '0;
    cfg.valid <= 1'b0;
    cfg.index <= '0;
    cfg.data <= '0;
    sender_steady = 1'b0;
    sink_steady = 1'b0;
    samples_sent = 0;
    writes_done = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // mixed gains, wide limit value masked, out-of-range index ignored
    plan = '{wr(REG_GAIN_P, 16'h0100), wr(REG_GAIN_I, 16'h0040),
             wr(REG_GAIN_OFFSET, 16'h0080), wr(REG_TARGET, 16'hFFF6),
             wr(REG_INT_LIMIT, 16'hFFFF), wr(REG_RATE_LIMIT, 16'h8003),
             wr(REG_NONE, 16'h0000), wr(REG_OUT_LIMIT, 16'hFF40)};
    program_regs(plan);
    probe = '{16'sd0, 16'sd1, -16'sd1, 16'sh7FFF, 16'sh8000, -16'sd10,
              16'sh5555, 16'shAAAA, 16'sd100, -16'sd100};
    foreach (probe[k]) send_sample(probe[k]);
    drain_corrections();

    // zero clamps and zero output limit
    plan = '{wr(REG_GAIN_P, 16'hFFFF), wr(REG_GAIN_I, 16'h0000),
             wr(REG_GAIN_OFFSET, 16'hFFFF), wr(REG_TARGET, 16'h7FFF),
             wr(REG_INT_LIMIT, 16'h0000), wr(REG_RATE_LIMIT, 16'h0000),
             wr(REG_OUT_LIMIT, 16'h0000)};
    program_regs(plan);
    probe = '{16'sh7FFF, 16'sh8000, 16'sd5, 16'sd0, -16'sd5};
    foreach (probe[k]) send_sample(probe[k]);
    drain_corrections();

    // integral path alone
    plan = '{wr(REG_GAIN_P, 16'h0000), wr(REG_GAIN_I, 16'h0001),
             wr(REG_GAIN_OFFSET, 16'h0000), wr(REG_TARGET, 16'h8000),
             wr(REG_INT_LIMIT, 16'h7FFF), wr(REG_RATE_LIMIT, 16'h7FFF),
             wr(REG_OUT_LIMIT, 16'h00FF)};
    program_regs(plan);
    probe = '{16'sd1, 16'sd2, 16'sd3, 16'sh8000, 16'sh7FFF};
    foreach (probe[k]) send_sample(probe[k]);

    for (int phase = 0; phase < RandomPhases; phase++) begin
      drain_corrections();
      plan = {};
      for (int r = 0; r < 7; r++) begin
        if (phase == 0) style = 1;
        else if (phase == 1) style = (r < 3) ? 1 : 0;
        else style = $urandom_range(0, 5);
        if (phase < 2 || $urandom_range(0, 3) != 0)
          plan.push_back(wr(r[IndexW-1:0], reg_value(r[IndexW-1:0], style)));
      end
      if ($urandom_range(0, 2) == 0) plan.push_back(wr(REG_NONE, DataW'($urandom())));
      plan.shuffle();
      program_regs(plan);
      sender_steady = ($urandom_range(0, 3) == 0);
      sink_steady = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PhaseItems; n++) begin
        if (n == PhaseItems / 2) drain_corrections();
        send_sample(pick_sample());
      end
    end

    // long runs of extreme samples at full rate
    drain_corrections();
    plan = '{wr(REG_GAIN_P, 16'h0000), wr(REG_GAIN_I, 16'h0001),
             wr(REG_GAIN_OFFSET, 16'h0000), wr(REG_INT_LIMIT, 16'h7FFF),
             wr(REG_OUT_LIMIT, 16'h00FF)};
    program_regs(plan);
    sender_steady = 1'b1;
    sink_steady = 1'b1;
    for (int n = 0; n < ExtremeItems; n++) send_sample(16'sh7FFF);
    for (int n = 0; n < ExtremeItems; n++) send_sample(16'sh8000);
    sender_steady = 1'b0;
    sink_steady = 1'b0;
    for (int n = 0; n < 40; n++) send_sample(pick_sample());

    drain_corrections();
    repeat (8) @(posedge clk);
    $display("sent %0d samples and %0d register writes, checked %0d corrections",
             samples_sent, writes_done, sb.checked);
    $display("running sum reached upper limit: %0d, lower limit: %0d",
             sb.hit_max, sb.hit_min);
    if (sb.mismatches == 0) begin
      $display("pid_motor_correction regression: pass");
    end else begin
      $display("pid_motor_correction regression: fail");
    end
    $finish;
  end

endmodule
